>>> sv/fte_pkg.sv
// Package for the floor table engine: command codes, entry layout, sequencer
// states and fixed constants. No dependencies.
`default_nettype none

package fte_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int CAP_RESET       = 32;

  localparam int ID_W    = 16;
  localparam int STATE_W = 2;
  localparam int LIMIT_W = 16;
  localparam int VALUE_W = 16;
  localparam int CFG_W   = 6;

  localparam logic [STATE_W-1:0] ST_WAITING = 2'd0;
  localparam logic [STATE_W-1:0] ST_INVALID = 2'd3;
  localparam logic [LIMIT_W-1:0] INIT_LIMIT = 16'd2;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX  = 16'hFFFF;

  typedef enum logic [3:0] {
    CMD_INSERT     = 4'd0,
    CMD_DELETE     = 4'd1,
    CMD_EXISTS     = 4'd2,
    CMD_SET_CHAIR  = 4'd3,
    CMD_GET_LIMIT  = 4'd4,
    CMD_SET_LIMIT  = 4'd5,
    CMD_SET_STATE  = 4'd6,
    CMD_GET_STATE  = 4'd7,
    CMD_POSITION   = 4'd8,
    CMD_GET_CHAIR  = 4'd9,
    CMD_CHAIR_USED = 4'd10,
    CMD_CLEAN      = 4'd11
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]    floor;
    logic [ID_W-1:0]    chair;
    logic [STATE_W-1:0] state;
    logic [LIMIT_W-1:0] limit;
  } entry_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_DECIDE,
    SEQ_SHIFT
  } seq_state_t;

endpackage

`default_nettype wire

>>> sv/fte_mem.sv
// Entry memory of the floor table engine: one write port, one read port with
// registered read data. Depends on fte_pkg for the entry layout.
`default_nettype none

module fte_mem #(
  parameter int  MAX_ENTRIES = fte_pkg::MAX_ENTRIES_DEF,
  localparam int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire fte_pkg::entry_t  wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output fte_pkg::entry_t       rdata
);

  fte_pkg::entry_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/fte_ctrl.sv
// Command sequencer of the floor table engine: key and chair scans, updates,
// the compacting delete and the result register. Depends on fte_pkg.
`default_nettype none

module fte_ctrl #(
  parameter int  MAX_ENTRIES = fte_pkg::MAX_ENTRIES_DEF,
  localparam int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CW          = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [3:0]                   cmd,
  input  wire logic [fte_pkg::ID_W-1:0]     floor_id,
  input  wire logic [fte_pkg::ID_W-1:0]     chair_id,
  input  wire logic [fte_pkg::LIMIT_W-1:0]  grant_limit,
  input  wire logic [fte_pkg::STATE_W-1:0]  new_state,
  input  wire logic [CW-1:0]                capacity,
  output logic                              empty,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output fte_pkg::entry_t                   mem_wdata,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_raddr,
  input  wire fte_pkg::entry_t              mem_rdata,
  output logic                              done,
  output logic                              error,
  output logic [fte_pkg::VALUE_W-1:0]       value
);

  fte_pkg::seq_state_t state, state_next;

  fte_pkg::cmd_t                    cmd_q;
  logic [fte_pkg::ID_W-1:0]         key_q, chair_q;
  logic [fte_pkg::LIMIT_W-1:0]      lim_q;
  logic [fte_pkg::STATE_W-1:0]      nst_q;
  logic [CW-1:0]                    idx, idx_next;
  logic                             rvalid, rvalid_next;
  logic [AW-1:0]                    ridx, ridx_next;
  logic                             found, found_next;
  logic [AW-1:0]                    pos, pos_next;
  fte_pkg::entry_t                  hit, hit_next;
  logic [CW-1:0]                    count, count_next;
  logic                             done_next, error_next;
  logic [fte_pkg::VALUE_W-1:0]      value_next;

  fte_pkg::cmd_t in_cmd;
  logic          in_keyed, in_ok, in_scan;
  logic          keyed, issue, match;
  logic [CW-1:0] count_inc;

  assign in_cmd   = fte_pkg::cmd_t'(cmd);
  assign in_keyed = in_cmd inside {[fte_pkg::CMD_INSERT:fte_pkg::CMD_GET_CHAIR]};
  assign in_ok    = !(in_keyed && floor_id == '0) &&
                    !(in_cmd == fte_pkg::CMD_SET_STATE && new_state == fte_pkg::ST_INVALID);
  assign in_scan  = in_ok && in_cmd inside {[fte_pkg::CMD_INSERT:fte_pkg::CMD_CHAIR_USED]};

  assign keyed     = cmd_q inside {[fte_pkg::CMD_INSERT:fte_pkg::CMD_GET_CHAIR]};
  assign issue     = (idx < count);
  assign match     = (cmd_q == fte_pkg::CMD_CHAIR_USED) ? (mem_rdata.chair == chair_q)
                                                        : (mem_rdata.floor == key_q);
  assign count_inc = CW'(count + 1'b1);
  assign busy      = (state != fte_pkg::SEQ_IDLE);
  assign empty     = (count == '0);

  always_comb begin
    state_next = state;
    case (state)
      fte_pkg::SEQ_IDLE: begin
        if (start) begin
          state_next = in_scan ? fte_pkg::SEQ_SCAN : fte_pkg::SEQ_DECIDE;
        end
      end
      fte_pkg::SEQ_SCAN: begin
        if ((rvalid && match) || (!issue && !rvalid)) begin
          state_next = fte_pkg::SEQ_DECIDE;
        end
      end
      fte_pkg::SEQ_DECIDE: begin
        if (cmd_q == fte_pkg::CMD_DELETE && found) begin
          state_next = fte_pkg::SEQ_SHIFT;
        end else begin
          state_next = fte_pkg::SEQ_IDLE;
        end
      end
      fte_pkg::SEQ_SHIFT: begin
        if (!issue && !rvalid) begin
          state_next = fte_pkg::SEQ_IDLE;
        end
      end
      default: state_next = fte_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    idx_next    = idx;
    rvalid_next = 1'b0;
    ridx_next   = ridx;
    found_next  = found;
    pos_next    = pos;
    hit_next    = hit;
    count_next  = count;
    done_next   = 1'b0;
    error_next  = 1'b0;
    value_next  = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = hit;
    mem_re      = 1'b0;
    mem_raddr   = idx[AW-1:0];

    case (state)
      fte_pkg::SEQ_IDLE: begin
        idx_next   = '0;
        found_next = 1'b0;
      end

      // Reads go out one per cycle; each compare looks at the word read the
      // cycle before.
      fte_pkg::SEQ_SCAN: begin
        mem_re      = issue;
        rvalid_next = issue;
        if (issue) begin
          idx_next  = CW'(idx + 1'b1);
          ridx_next = idx[AW-1:0];
        end
        if (rvalid && match) begin
          found_next = 1'b1;
          pos_next   = ridx;
          hit_next   = mem_rdata;
        end
      end

      fte_pkg::SEQ_DECIDE: begin
        done_next = 1'b1;
        if (keyed && key_q == '0) begin
          error_next = 1'b1;
        end else if (cmd_q == fte_pkg::CMD_SET_STATE && nst_q == fte_pkg::ST_INVALID) begin
          error_next = 1'b1;
        end else if (cmd_q == fte_pkg::CMD_INSERT) begin
          if (found || count >= capacity || count >= CW'(MAX_ENTRIES)) begin
            error_next = 1'b1;
          end else begin
            mem_we          = 1'b1;
            mem_waddr       = count[AW-1:0];
            mem_wdata.floor = key_q;
            mem_wdata.chair = chair_q;
            mem_wdata.state = fte_pkg::ST_WAITING;
            mem_wdata.limit = fte_pkg::INIT_LIMIT;
            count_next      = count_inc;
            value_next      = fte_pkg::VALUE_W'(count_inc);
          end
        end else if ((keyed || cmd_q == fte_pkg::CMD_CHAIR_USED) && !found) begin
          error_next = 1'b1;
        end else begin
          mem_waddr = pos;
          case (cmd_q)
            fte_pkg::CMD_DELETE: begin
              // The result follows once the later entries have moved down.
              done_next = 1'b0;
              idx_next  = CW'(CW'(pos) + 1'b1);
            end
            fte_pkg::CMD_SET_CHAIR: begin
              mem_we          = 1'b1;
              mem_wdata.chair = chair_q;
            end
            fte_pkg::CMD_GET_LIMIT: value_next = hit.limit;
            fte_pkg::CMD_SET_LIMIT: begin
              mem_we = 1'b1;
              if (lim_q == '0 || lim_q == fte_pkg::LIMIT_MAX) begin
                mem_wdata.limit = fte_pkg::LIMIT_MAX;
              end else begin
                mem_wdata.limit = fte_pkg::LIMIT_W'(lim_q + 1'b1);
              end
            end
            fte_pkg::CMD_SET_STATE: begin
              mem_we          = 1'b1;
              mem_wdata.state = nst_q;
            end
            fte_pkg::CMD_GET_STATE: value_next = fte_pkg::VALUE_W'(hit.state);
            fte_pkg::CMD_POSITION:  value_next = fte_pkg::VALUE_W'(pos);
            fte_pkg::CMD_GET_CHAIR: value_next = hit.chair;
            fte_pkg::CMD_CLEAN:     count_next = '0;
            default: ;
          endcase
        end
      end

      // Entry i is read while entry i-1 is written back one place lower, so
      // a read never meets a pending write to the same address.
      fte_pkg::SEQ_SHIFT: begin
        mem_re      = issue;
        rvalid_next = issue;
        if (issue) begin
          idx_next  = CW'(idx + 1'b1);
          ridx_next = idx[AW-1:0];
        end
        if (rvalid) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(ridx - 1'b1);
          mem_wdata = mem_rdata;
        end
        if (!issue && !rvalid) begin
          done_next  = 1'b1;
          count_next = CW'(count - 1'b1);
          value_next = fte_pkg::VALUE_W'(CW'(count - 1'b1));
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= fte_pkg::SEQ_IDLE;
      count  <= '0;
      idx    <= '0;
      rvalid <= 1'b0;
      found  <= 1'b0;
      done   <= 1'b0;
      error  <= 1'b0;
      value  <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      idx    <= idx_next;
      rvalid <= rvalid_next;
      found  <= found_next;
      done   <= done_next;
      error  <= error_next;
      value  <= value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fte_pkg::SEQ_IDLE && start) begin
      cmd_q   <= in_cmd;
      key_q   <= floor_id;
      chair_q <= chair_id;
      lim_q   <= grant_limit;
      nst_q   <= new_state;
    end
    ridx <= ridx_next;
    pos  <= pos_next;
    hit  <= hit_next;
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == fte_pkg::SEQ_DECIDE || $past(state) == fte_pkg::SEQ_SHIFT))
    else $error("result strobe without a finishing sequencer step");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == fte_pkg::SEQ_DECIDE || state == fte_pkg::SEQ_SHIFT))
    else $error("memory write during a scan or while idle");

  a_error_value: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (value == '0))
    else $error("error result carries a nonzero value");

  a_scan_hit: assert property (@(posedge clk) disable iff (rst)
    (state == fte_pkg::SEQ_SCAN && rvalid && match) |=> found)
    else $error("scan match not recorded");

endmodule

`default_nettype wire

>>> sv/floor_table_engine.sv
// Top level of the floor table engine: capacity register, entry memory and
// command sequencer. Depends on fte_pkg, fte_mem and fte_ctrl.
//
//   Channel   Handshake                 Payload
//   command   start / busy              cmd, floor_id, chair_id, grant_limit, new_state
//   result    done (one-cycle strobe)   error, value
//   config    cfg_we                    cfg_data (capacity)
//
// A command is taken when start is high and busy is low; its result appears
// on done in the same cycle that busy falls.
// Key and chair searches read one stored entry per cycle and stop at the first
// match or after the last used entry.
// Delete adds a shift pass that moves each later entry down one place,
// also when the last entry goes and nothing is left to move.
// Commands with a bad key or state, clean and unknown codes skip the scan.
// Reset clears the count and sets capacity; the memory needs no clearing.
// The result side cannot stall; each result must be taken in its cycle.
`default_nettype none

module floor_table_engine #(
  parameter int MAX_ENTRIES = fte_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [3:0]                   cmd,
  input  wire logic [fte_pkg::ID_W-1:0]     floor_id,
  input  wire logic [fte_pkg::ID_W-1:0]     chair_id,
  input  wire logic [fte_pkg::LIMIT_W-1:0]  grant_limit,
  input  wire logic [fte_pkg::STATE_W-1:0]  new_state,
  input  wire logic                         cfg_we,
  input  wire logic [fte_pkg::CFG_W-1:0]    cfg_data,
  output logic                              done,
  output logic                              error,
  output logic [fte_pkg::VALUE_W-1:0]       value
);

  localparam int AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW      = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_RST = (fte_pkg::CAP_RESET > MAX_ENTRIES) ? MAX_ENTRIES
                                                              : fte_pkg::CAP_RESET;

  logic [CW-1:0]   capacity, cap_clamped;
  logic            empty;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  fte_pkg::entry_t mem_wdata, mem_rdata;

  always_comb begin
    if (cfg_data == '0) begin
      cap_clamped = CW'(1);
    end else if (int'(cfg_data) > MAX_ENTRIES) begin
      cap_clamped = CW'(MAX_ENTRIES);
    end else begin
      cap_clamped = CW'(cfg_data);
    end
  end

  // Capacity only changes while the table is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CW'(CAP_RST);
    end else if (cfg_we && empty) begin
      capacity <= cap_clamped;
    end
  end

  fte_mem #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fte_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .floor_id    (floor_id),
    .chair_id    (chair_id),
    .grant_limit (grant_limit),
    .new_state   (new_state),
    .capacity    (capacity),
    .empty       (empty),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .done        (done),
    .error       (error),
    .value       (value)
  );

endmodule

`default_nettype wire
